// ===== rtl/rmth_pkg.sv =====
// Package for the running median core: shared constants, types and helpers.
// No dependencies.
`default_nettype none
package rmth_pkg;
   localparam int DefaultCapacity = 1024;
   localparam int SampleWidth = 32;
   localparam int MedianWidth = 33;
   localparam int CountWidth = 11;

   // Which heap an operation works on.
   typedef enum logic {
      HEAP_LOWER = 1'b0,
      HEAP_UPPER = 1'b1
   } heap_sel_type;

   // Insertion plan made by the front part.
   typedef enum logic [1:0] {
      PLAN_DROP      = 2'd0,
      PLAN_PUSH      = 2'd1,
      PLAN_MOVE_PUSH = 2'd2
   } plan_type;

   // Back-part sequencer states.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DOWN_RDL,
      ST_DOWN_RDR,
      ST_DOWN_CMP,
      ST_DOWN_WR,
      ST_UP_RD,
      ST_UP_CMP,
      ST_UP_WR,
      ST_REPORT
   } state_type;

   // One classified item passed from front to back.
   typedef struct packed {
      plan_type     plan;
      heap_sel_type dst;
      logic [SampleWidth-1:0] sample;
   } job_type;

   // true if a belongs above b (max-heap for the lower half)
   function automatic logic heap_before(heap_sel_type h, logic signed [SampleWidth-1:0] a,
                                        logic signed [SampleWidth-1:0] b);
      heap_before = (h == HEAP_LOWER) ? (a > b) : (a < b);
   endfunction
endpackage
`default_nettype wire

// ===== rtl/rmth_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none
module rmth_ram #(
   parameter int Width = 32,
   parameter int Depth = 512,
   parameter int AddrWidth = (Depth > 1) ? $clog2(Depth) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 we,
   input  wire logic [AddrWidth-1:0] addr,
   input  wire logic [Width-1:0]     wdata,
   output logic      [Width-1:0]     rdata
);
   logic [Width-1:0] mem [Depth];

   // write or read one entry
   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule
`default_nettype wire

// ===== rtl/rmth_front.sv =====
// Front part: accepts samples, classifies them against the heap tops, queues jobs.
// Depends on rmth_pkg.
`default_nettype none
module rmth_front import rmth_pkg::*; #(
   parameter int Capacity = DefaultCapacity,
   parameter int SizeWidth = $clog2(Capacity + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [SampleWidth-1:0] req_sample,
   // heap view from the back part, valid while it is idle
   input  wire logic                   back_idle,
   input  wire logic [SizeWidth-1:0]   lower_size,
   input  wire logic [SizeWidth-1:0]   upper_size,
   input  wire logic [SampleWidth-1:0] lower_top,
   input  wire logic [SampleWidth-1:0] upper_top,
   output logic                        job_valid,
   input  wire logic                   job_ready,
   output job_type                     job
);
   // Two-entry job queue; a new item is classified only once the back part
   // has settled the previous one, since the plan depends on its result.
   job_type          q_ff [2];
   job_type          q_in [2];
   logic [1:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             rd_ptr_ff, rd_ptr_in, wr_ptr_ff, wr_ptr_in;
   job_type          cls;
   logic             push, pop;
   logic signed [SampleWidth-1:0] s, lt, ut;
   logic signed [MedianWidth:0] med2, s2;

   assign s  = req_sample;
   assign lt = lower_top;
   assign ut = upper_top;
   assign med2 = {{2{lt[SampleWidth-1]}}, lt} + {{2{ut[SampleWidth-1]}}, ut};
   assign s2   = {{1{s[SampleWidth-1]}}, s, 1'b0};

   // classify the sample
   always_comb begin
      cls.sample = req_sample;
      cls.plan   = PLAN_PUSH;
      cls.dst    = HEAP_LOWER;
      priority if ({1'b0, lower_size} + {1'b0, upper_size} >= (SizeWidth+1)'(Capacity)) begin
         cls.plan = PLAN_DROP;
      end else if (lower_size == '0) begin
         cls.dst = HEAP_LOWER;
      end else if (lower_size == upper_size) begin
         cls.dst = (s2 <= med2) ? HEAP_LOWER : HEAP_UPPER;
      end else if (lower_size < upper_size) begin
         if (s > ut) begin
            cls.plan = PLAN_MOVE_PUSH;
            cls.dst  = HEAP_UPPER;
         end
      end else begin
         cls.dst = HEAP_UPPER;
         if (s < lt) begin
            cls.plan = PLAN_MOVE_PUSH;
            cls.dst  = HEAP_LOWER;
         end
      end
   end

   assign req_ready = back_idle && !busy_ff && (cnt_ff == 2'd0);
   assign push      = req_valid && req_ready;
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ptr_ff];
   assign pop       = job_valid && job_ready;

   // advance queue pointers and track the item in flight
   always_comb begin
      q_in      = q_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      if (push) begin
         q_in[wr_ptr_ff] = cls;
         wr_ptr_in       = ~wr_ptr_ff;
      end
      if (pop) rd_ptr_in = ~rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
      if (pop) busy_in = 1'b1;
      else if (busy_ff && back_idle) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         busy_ff   <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         busy_ff   <= busy_in;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/rmth_back.sv =====
// Back part: heap sequencer doing sift-down and sift-up walks on two RAMs, then reports.
// Depends on rmth_pkg and rmth_ram.
`default_nettype none
module rmth_back import rmth_pkg::*; #(
   parameter int Capacity = DefaultCapacity,
   parameter int HeapDepth = (Capacity + 1) / 2,
   parameter int AddrWidth = (HeapDepth > 1) ? $clog2(HeapDepth) : 1,
   parameter int SizeWidth = $clog2(Capacity + 1)
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   job_valid,
   output logic                        job_ready,
   input  wire job_type                job,
   output logic                        back_idle,
   output logic [SizeWidth-1:0]        lower_size,
   output logic [SizeWidth-1:0]        upper_size,
   output logic [SampleWidth-1:0]      lower_top,
   output logic [SampleWidth-1:0]      upper_top,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [MedianWidth-1:0]      rsp_median_doubled,
   output logic [CountWidth-1:0]       rsp_stored_count,
   output logic                        rsp_dropped
);
   localparam int IdxWidth = AddrWidth + 2;

   state_type              state_ff, state_in;
   logic [SizeWidth-1:0]   lsz_ff, lsz_in, usz_ff, usz_in;
   logic [SampleWidth-1:0] ltop_ff, ltop_in, utop_ff, utop_in;
   heap_sel_type           hp_ff, hp_in;
   logic                   drop_ff, drop_in;
   logic [SampleWidth-1:0] v_ff, v_in, mv_ff, mv_in, ch_ff, ch_in;
   logic [IdxWidth-1:0]    i_ff, i_in, n_ff, n_in;
   logic                   rv_ff, rv_in;
   logic [MedianWidth-1:0] rmed_ff, rmed_in;
   logic [CountWidth-1:0]  rcnt_ff, rcnt_in;
   logic                   rdrop_ff, rdrop_in;

   // RAM ports
   logic                   we, we_l, we_u;
   logic [AddrWidth-1:0]   addr;
   logic [SampleWidth-1:0] wdata, rd_l, rd_u, rd;

   // walk helpers
   logic [IdxWidth-1:0]    left, right, parent, best_idx;
   logic                   has_left, has_right, right_wins, lone_go, pair_go, up_go;
   logic [SampleWidth-1:0] best, dst_top;
   logic [SizeWidth-1:0]   dst_sz, other_sz;
   logic [SizeWidth:0]     total;
   logic signed [MedianWidth-1:0] mdbl;
   logic signed [SampleWidth-1:0] lt, ut;

   rmth_ram #(.Width(SampleWidth), .Depth(HeapDepth)) u_lower (
      .clock(clock), .we(we_l), .addr(addr), .wdata(wdata), .rdata(rd_l));
   rmth_ram #(.Width(SampleWidth), .Depth(HeapDepth)) u_upper (
      .clock(clock), .we(we_u), .addr(addr), .wdata(wdata), .rdata(rd_u));

   assign we_l = we && (hp_ff == HEAP_LOWER);
   assign we_u = we && (hp_ff == HEAP_UPPER);
   assign rd   = (hp_ff == HEAP_LOWER) ? rd_l : rd_u;

   // child and parent positions of the current hole
   assign left      = {i_ff[IdxWidth-2:0], 1'b1};
   assign right     = left + IdxWidth'(1);
   assign parent    = (i_ff - IdxWidth'(1)) >> 1;
   assign has_left  = (left < n_ff);
   assign has_right = (right < n_ff);

   // pick the child that ranks higher; ch_ff holds the left one, rd the right one
   assign right_wins = heap_before(hp_ff, rd, ch_ff);
   assign best       = right_wins ? rd : ch_ff;
   assign best_idx   = right_wins ? right : left;
   assign lone_go    = heap_before(hp_ff, rd, v_ff);
   assign pair_go    = heap_before(hp_ff, best, v_ff);
   assign up_go      = heap_before(hp_ff, v_ff, rd);

   assign dst_sz   = (job.dst == HEAP_LOWER) ? lsz_ff : usz_ff;
   assign dst_top  = (job.dst == HEAP_LOWER) ? ltop_ff : utop_ff;
   assign other_sz = (hp_ff == HEAP_LOWER) ? usz_ff : lsz_ff;
   assign total    = {1'b0, lsz_ff} + {1'b0, usz_ff};

   // doubled median of the current sizes and tops
   assign lt = ltop_ff;
   assign ut = utop_ff;
   always_comb begin
      priority if (lsz_ff == '0 && usz_ff == '0) mdbl = '0;
      else if (lsz_ff == usz_ff) mdbl = {lt[SampleWidth-1], lt} + {ut[SampleWidth-1], ut};
      else if (lsz_ff < usz_ff) mdbl = {ut, 1'b0};
      else mdbl = {lt, 1'b0};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               if (job.plan == PLAN_DROP) state_in = ST_REPORT;
               else if (job.plan == PLAN_MOVE_PUSH) state_in = ST_DOWN_RDL;
               else state_in = ST_UP_RD;
            end
         end
         ST_DOWN_RDL: state_in = has_left ? ST_DOWN_RDR : ST_DOWN_WR;
         ST_DOWN_RDR: begin
            if (has_right) state_in = ST_DOWN_CMP;
            else if (lone_go) state_in = ST_DOWN_RDL;
            else state_in = ST_DOWN_WR;
         end
         ST_DOWN_CMP: state_in = pair_go ? ST_DOWN_RDL : ST_DOWN_WR;
         ST_DOWN_WR:  state_in = ST_UP_RD;
         ST_UP_RD:    state_in = (i_ff == '0) ? ST_UP_WR : ST_UP_CMP;
         ST_UP_CMP:   state_in = up_go ? ST_UP_RD : ST_UP_WR;
         ST_UP_WR:    state_in = ST_REPORT;
         ST_REPORT:   state_in = (!rv_ff || rsp_ready) ? ST_IDLE : ST_REPORT;
         default:     state_in = ST_IDLE;
      endcase
   end

   // datapath and RAM control
   always_comb begin
      lsz_in = lsz_ff;  usz_in = usz_ff;
      ltop_in = ltop_ff; utop_in = utop_ff;
      hp_in = hp_ff; drop_in = drop_ff;
      v_in = v_ff; mv_in = mv_ff; ch_in = ch_ff;
      i_in = i_ff; n_in = n_ff;
      rv_in = rv_ff; rmed_in = rmed_ff; rcnt_in = rcnt_ff; rdrop_in = rdrop_ff;
      we = 1'b0; addr = AddrWidth'(i_ff); wdata = v_ff;
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               // a move replaces the top of dst with the sample and sifts it down;
               // the old top then goes into the other heap
               hp_in   = job.dst;
               v_in    = job.sample;
               drop_in = (job.plan == PLAN_DROP);
               mv_in   = dst_top;
               n_in    = IdxWidth'(dst_sz);
               i_in    = (job.plan == PLAN_MOVE_PUSH) ? '0 : IdxWidth'(dst_sz);
            end
         end
         ST_DOWN_RDL: begin
            addr = AddrWidth'(left);
         end
         ST_DOWN_RDR: begin
            // left child arrives; fetch the right one or settle a lone child
            ch_in = rd;
            if (has_right) begin
               addr = AddrWidth'(right);
            end else if (lone_go) begin
               we = 1'b1; addr = AddrWidth'(i_ff); wdata = rd;
               i_in = left;
            end
         end
         ST_DOWN_CMP: begin
            if (pair_go) begin
               we = 1'b1; addr = AddrWidth'(i_ff); wdata = best;
               i_in = best_idx;
            end
         end
         ST_DOWN_WR: begin
            we = 1'b1; addr = AddrWidth'(i_ff); wdata = v_ff;
            hp_in = (hp_ff == HEAP_LOWER) ? HEAP_UPPER : HEAP_LOWER;
            v_in  = mv_ff;
            i_in  = IdxWidth'(other_sz);
         end
         ST_UP_RD: begin
            addr = AddrWidth'(parent);
         end
         ST_UP_CMP: begin
            if (up_go) begin
               we = 1'b1; addr = AddrWidth'(i_ff); wdata = rd;
               i_in = parent;
            end
         end
         ST_UP_WR: begin
            we = 1'b1; addr = AddrWidth'(i_ff); wdata = v_ff;
            if (hp_ff == HEAP_LOWER) lsz_in = lsz_ff + 1'b1;
            else usz_in = usz_ff + 1'b1;
         end
         ST_REPORT: begin
            if (!rv_ff || rsp_ready) begin
               rv_in    = 1'b1;
               rmed_in  = mdbl;
               rcnt_in  = CountWidth'(total);
               rdrop_in = drop_ff;
            end
         end
         default: ;
      endcase
      // a write at the root refreshes that heap's cached top
      if (we && addr == '0) begin
         if (hp_ff == HEAP_LOWER) ltop_in = wdata;
         else utop_in = wdata;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lsz_ff   <= '0;
         usz_ff   <= '0;
         ltop_ff  <= '0;
         utop_ff  <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         lsz_ff   <= lsz_in;
         usz_ff   <= usz_in;
         ltop_ff  <= ltop_in;
         utop_ff  <= utop_in;
         rv_ff    <= rv_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      hp_ff    <= hp_in;
      drop_ff  <= drop_in;
      v_ff     <= v_in;
      mv_ff    <= mv_in;
      ch_ff    <= ch_in;
      i_ff     <= i_in;
      n_ff     <= n_in;
      rmed_ff  <= rmed_in;
      rcnt_ff  <= rcnt_in;
      rdrop_ff <= rdrop_in;
   end

   assign job_ready  = (state_ff == ST_IDLE);
   assign back_idle  = (state_ff == ST_IDLE);
   assign lower_size = lsz_ff;
   assign upper_size = usz_ff;
   assign lower_top  = ltop_ff;
   assign upper_top  = utop_ff;
   assign rsp_valid  = rv_ff;
   assign rsp_median_doubled = rmed_ff;
   assign rsp_stored_count   = rcnt_ff;
   assign rsp_dropped        = rdrop_ff;
endmodule
`default_nettype wire

// ===== rtl/running_median_two_heaps_core.sv =====
// Top level of the running median core: front classifier, job queue, heap back end.
// Depends on rmth_pkg, rmth_front, rmth_back, rmth_ram.
`default_nettype none
// Each beat on req carries one signed sample; each produces exactly one rsp beat with twice
// the running median, the stored count and a drop flag (set once Capacity samples are held).
// The samples sit in two heap RAMs of (Capacity+1)/2 entries with one port each. Items are
// handled one at a time: a dropped sample goes straight to the report, a sample that
// lands in one heap climbs from its end level by level, and a sample that moves a top
// across first sifts down from the root of its heap; the old top then climbs in the
// other heap. The result waits in a one-beat output register; a stalled receiver holds
// the next result back.
// No clearing pass is needed after reset.
module running_median_two_heaps_core import rmth_pkg::*; #(
   parameter int Capacity = DefaultCapacity
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [SampleWidth-1:0] req_sample,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [MedianWidth-1:0]      rsp_median_doubled,
   output logic [CountWidth-1:0]       rsp_stored_count,
   output logic                        rsp_dropped
);
   localparam int SizeWidth = $clog2(Capacity + 1);

   logic                   job_valid, job_ready, back_idle;
   job_type                job;
   logic [SizeWidth-1:0]   lower_size, upper_size;
   logic [SampleWidth-1:0] lower_top, upper_top;

   rmth_front #(.Capacity(Capacity), .SizeWidth(SizeWidth)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_sample,
      .back_idle, .lower_size, .upper_size, .lower_top, .upper_top,
      .job_valid, .job_ready, .job);

   rmth_back #(.Capacity(Capacity), .SizeWidth(SizeWidth)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job, .back_idle,
      .lower_size, .upper_size, .lower_top, .upper_top,
      .rsp_valid, .rsp_ready, .rsp_median_doubled, .rsp_stored_count, .rsp_dropped);

   // heap sizes never differ by more than one when the back end is idle
   assert property (@(posedge clock) disable iff (reset)
      back_idle |-> ((lower_size == upper_size) || (lower_size == upper_size + 1'b1)
                     || (upper_size == lower_size + 1'b1)))
      else $error("heap sizes out of balance");

   // a dropped sample reports a full store
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_dropped) |-> ({1'b0, lower_size} + {1'b0, upper_size}
                                      == (SizeWidth+1)'(Capacity)))
      else $error("drop flagged while store not full");

   // no new sample accepted while the back end works
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |-> back_idle)
      else $error("sample accepted while busy");
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for running_median_two_heaps_core: drives signed samples, predicts the doubled
// running median, count and drop flag with a behavioral two-heap model, checks every rsp beat.
// Depends on rmth_pkg and the core RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import rmth_pkg::*;

   localparam int Capacity = DefaultCapacity;
   localparam int HeapDepth = (Capacity + 1) / 2;
   localparam longint CycleLimit = 2000000;

   typedef struct packed {
      logic [MedianWidth-1:0] median_doubled;
      logic [CountWidth-1:0]  stored_count;
      logic                   dropped;
   } median_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [SampleWidth-1:0] req_sample = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [MedianWidth-1:0] rsp_median_doubled;
   logic [CountWidth-1:0] rsp_stored_count;
   logic rsp_dropped;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int error_count = 0;
   longint cycle_count = 0;
   median_result_type expected_medians[$];

   // predictor state
   logic signed [SampleWidth-1:0] low_heap[HeapDepth];
   logic signed [SampleWidth-1:0] high_heap[HeapDepth];
   int low_size = 0;
   int high_size = 0;

   running_median_two_heaps_core #(.Capacity(Capacity)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_sample(req_sample),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_median_doubled(rsp_median_doubled), .rsp_stored_count(rsp_stored_count),
      .rsp_dropped(rsp_dropped)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // true if a sits above b: max order for the lower heap, min order for the upper
   function automatic bit ranks_above(heap_sel_type h, logic signed [SampleWidth-1:0] a,
                                      logic signed [SampleWidth-1:0] b);
      return (h == HEAP_LOWER) ? (a > b) : (a < b);
   endfunction

   task automatic heap_insert(heap_sel_type h, logic signed [SampleWidth-1:0] v);
      int i;
      int p;
      i = (h == HEAP_LOWER) ? low_size : high_size;
      if (h == HEAP_LOWER) low_size++; else high_size++;
      while (i > 0) begin
         p = (i - 1) / 2;
         if (h == HEAP_LOWER) begin
            if (!ranks_above(h, v, low_heap[p])) break;
            low_heap[i] = low_heap[p];
         end else begin
            if (!ranks_above(h, v, high_heap[p])) break;
            high_heap[i] = high_heap[p];
         end
         i = p;
      end
      if (h == HEAP_LOWER) low_heap[i] = v; else high_heap[i] = v;
   endtask

   task automatic heap_remove_top(heap_sel_type h);
      int n;
      int i;
      int c;
      logic signed [SampleWidth-1:0] v;
      i = 0;
      n = ((h == HEAP_LOWER) ? low_size : high_size) - 1;
      if (h == HEAP_LOWER) low_size = n; else high_size = n;
      if (n == 0) return;
      v = (h == HEAP_LOWER) ? low_heap[n] : high_heap[n];
      forever begin
         c = 2 * i + 1;
         if (c >= n) break;
         if (h == HEAP_LOWER) begin
            if (c + 1 < n && ranks_above(h, low_heap[c+1], low_heap[c])) c++;
            if (!ranks_above(h, low_heap[c], v)) break;
            low_heap[i] = low_heap[c];
         end else begin
            if (c + 1 < n && ranks_above(h, high_heap[c+1], high_heap[c])) c++;
            if (!ranks_above(h, high_heap[c], v)) break;
            high_heap[i] = high_heap[c];
         end
         i = c;
      end
      if (h == HEAP_LOWER) low_heap[i] = v; else high_heap[i] = v;
   endtask

   function automatic longint doubled_median();
      if (low_size == 0 && high_size == 0) return 0;
      if (low_size == high_size) return longint'(low_heap[0]) + longint'(high_heap[0]);
      if (low_size < high_size) return 2 * longint'(high_heap[0]);
      return 2 * longint'(low_heap[0]);
   endfunction

   // fold one sample into the predictor and queue the expected rsp beat
   task automatic predict_median(logic signed [SampleWidth-1:0] s);
      median_result_type r;
      logic signed [SampleWidth-1:0] t;
      r.dropped = 1'b0;
      if (low_size + high_size >= Capacity) begin
         r.dropped = 1'b1;
      end else if (low_size == 0) begin
         heap_insert(HEAP_LOWER, s);
      end else if (low_size == high_size) begin
         if (2 * longint'(s) <= doubled_median()) heap_insert(HEAP_LOWER, s);
         else heap_insert(HEAP_UPPER, s);
      end else if (low_size < high_size) begin
         if (s > high_heap[0]) begin
            t = high_heap[0];
            heap_remove_top(HEAP_UPPER);
            heap_insert(HEAP_LOWER, t);
            heap_insert(HEAP_UPPER, s);
         end else begin
            heap_insert(HEAP_LOWER, s);
         end
      end else begin
         if (s < low_heap[0]) begin
            t = low_heap[0];
            heap_remove_top(HEAP_LOWER);
            heap_insert(HEAP_UPPER, t);
            heap_insert(HEAP_LOWER, s);
         end else begin
            heap_insert(HEAP_UPPER, s);
         end
      end
      r.median_doubled = MedianWidth'(doubled_median());
      r.stored_count = CountWidth'(low_size + high_size);
      expected_medians.push_back(r);
   endtask

   task automatic report_mismatch(string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   // send one sample beat, with an optional random idle gap first
   task automatic send_sample(logic [SampleWidth-1:0] s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= s;
      predict_median(s);
      do @(posedge clock); while (!req_ready);
   endtask

   // receiver side: random stalls and checking of each accepted beat
   always @(posedge clock) begin
      median_result_type exp_r;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_medians.size() == 0) begin
            report_mismatch("rsp beat with nothing expected");
         end else begin
            exp_r = expected_medians.pop_front();
            if (rsp_median_doubled !== exp_r.median_doubled)
               report_mismatch($sformatf("median_doubled %h, expected %h",
                                         rsp_median_doubled, exp_r.median_doubled));
            if (rsp_stored_count !== exp_r.stored_count)
               report_mismatch($sformatf("stored_count %0d, expected %0d",
                                         rsp_stored_count, exp_r.stored_count));
            if (rsp_dropped !== exp_r.dropped)
               report_mismatch($sformatf("dropped %b, expected %b",
                                         rsp_dropped, exp_r.dropped));
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [SampleWidth-1:0] random_sample();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(40) - 20;
         2: return {$urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFF0} + $urandom_range(15);
         default: return $urandom_range(1000);
      endcase
   endfunction

   task automatic set_idling(int send_pct, int recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
   endtask

   // extremes, ties, wide sums and every rebalance path
   task automatic test_directed();
      logic [SampleWidth-1:0] seq[$];
      seq = {32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0,
             32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'h5, 32'h5, 32'h5,
             32'hFFFF_FFFB, 32'h100, 32'hFFFF_FF00, 32'hAAAA_AAAA, 32'h5555_5555,
             32'h0, 32'h0, 32'h3};
      foreach (seq[i]) send_sample(seq[i]);
   endtask

   task automatic test_random(int n, int send_pct, int recv_pct);
      set_idling(send_pct, recv_pct);
      repeat (n) send_sample(random_sample());
   endtask

   // fill to capacity, then push dropped samples past it
   task automatic test_full_store();
      set_idling(0, 0);
      while (low_size + high_size < Capacity) send_sample(random_sample());
      set_idling(30, 30);
      repeat (20) send_sample(random_sample());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(200, 0, 0);
      test_random(200, 56, 0);
      test_random(200, 0, 56);
      test_random(200, 17, 17);
      test_random(100, 0, 0);
      test_full_store();
      test_random(350, 56, 56);
      req_valid <= 1'b0;
      set_idling(0, 0);
      while (expected_medians.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

// ===== files.f =====
rtl/rmth_pkg.sv
rtl/rmth_ram.sv
rtl/rmth_front.sv
rtl/rmth_back.sv
rtl/running_median_two_heaps_core.sv
verif/tb_top.sv
